FILE: rtl/sls_pkg.sv
// sls_pkg: request and result beat types and shared constants for the
// sortable lifo stack; no dependencies
`default_nettype none

package sls_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_SORT = 2'd3
    } t_req_kind;

    localparam logic [31:0] EMPTY_READ = 32'hFFFF_FF80;

    typedef struct packed {
        t_req_kind          req_type;
        logic signed [31:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               empty_error;
        logic               full_drop;
        logic [8:0]         item_count;
        logic               now_empty;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/sortable_lifo_stack.sv
// sortable_lifo_stack: bounded lifo stack of signed words with an in-place sort
// through an auxiliary stack; one compare unit under a small sequencer
// depends on sls_pkg
`default_nettype none

// A request beat is taken when start is high and busy is low; its single result
// beat appears on o_rsp for one cycle with o_done high and cannot be held off.
// Push answers in the cycle after it is taken and pushes may follow back to back.
// Pop and peek answer through the registered read of the main store and S_RD;
// an empty stack is answered as a push is. Sort takes each word off the main
// stack as a pivot; while it is less than the auxiliary top, that word moves
// back (a word moved back is taken off again), else the pivot goes onto the
// auxiliary stack, which is poured back at the end; all through one compare and
// one read port on each store. Pop or peek of an empty stack returns -128 with
// empty_error; a push to a full stack is dropped with full_drop.
module sortable_lifo_stack
    import sls_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_BITS   = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_SP   = 8'b0000_0100,
        S_SL   = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_WAIT = 8'b0010_0000,
        S_POUR = 8'b0100_0000,
        S_PW   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_mc, n_mc;
    logic [CW-1:0]       r_ac, n_ac;
    logic                r_pop, n_pop;
    logic [WORD_BITS-1:0] r_pivot, n_pivot;
    logic                r_done, n_done;
    t_rsp                r_rsp, n_rsp;

    logic [WORD_BITS-1:0] main_mem [STACK_DEPTH];
    logic [WORD_BITS-1:0] aux_mem  [STACK_DEPTH];
    logic [WORD_BITS-1:0] r_main_q, r_aux_q;

    logic                 main_we, aux_we;
    logic [WORD_BITS-1:0] main_wd;
    logic [CW-1:0]        mc_dec, ac_dec;
    logic [63:0]          push_w64, main_q64;
    logic                 accept, pivot_less;

    assign accept     = start && !busy;
    assign mc_dec     = r_mc - CW'(1);
    assign ac_dec     = r_ac - CW'(1);
    assign push_w64   = {32'd0, i_req.push_value};
    assign main_q64   = 64'(signed'(r_main_q));
    assign pivot_less = $signed(r_pivot) < $signed(r_aux_q);

    always_comb begin
        n_state  = r_state;
        n_mc     = r_mc;
        n_ac     = r_ac;
        n_pop    = r_pop;
        n_pivot  = r_pivot;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        main_we  = 1'b0;
        main_wd  = r_aux_q;
        aux_we   = 1'b0;
        n_rsp.empty_error = 1'b0;
        n_rsp.full_drop   = 1'b0;
        n_rsp.read_value  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            n_done = 1'b1;
                            if (r_mc < FULL_CNT) begin
                                main_we = 1'b1;
                                main_wd = push_w64[WORD_BITS-1:0];
                                n_mc    = r_mc + CW'(1);
                            end else begin
                                n_rsp.full_drop = 1'b1;
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            n_pop = (i_req.req_type == REQ_POP);
                            if (r_mc == '0) begin
                                n_done            = 1'b1;
                                n_rsp.empty_error = 1'b1;
                                n_rsp.read_value  = EMPTY_READ;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_ac    = '0;
                            n_state = S_SP;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_done           = 1'b1;
                n_rsp.read_value = main_q64[31:0];
                if (r_pop) begin
                    n_mc = mc_dec;
                end
                n_state = S_IDLE;
            end
            S_SP: begin
                if (r_mc == '0) begin
                    n_state = S_POUR;
                end else begin
                    n_mc    = mc_dec;
                    n_state = S_SL;
                end
            end
            S_SL: begin
                n_pivot = r_main_q;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_ac != '0 && pivot_less) begin
                    main_we = 1'b1;
                    n_mc    = r_mc + CW'(1);
                    n_ac    = ac_dec;
                    n_state = S_WAIT;
                end else begin
                    if (r_ac < FULL_CNT) begin
                        aux_we = 1'b1;
                        n_ac   = r_ac + CW'(1);
                    end
                    n_state = S_SP;
                end
            end
            S_WAIT: begin
                n_state = S_CMP;
            end
            S_POUR: begin
                if (r_ac == '0 || r_mc == FULL_CNT) begin
                    n_ac    = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PW;
                end
            end
            S_PW: begin
                main_we = 1'b1;
                n_mc    = r_mc + CW'(1);
                n_ac    = ac_dec;
                n_state = S_POUR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp.item_count = 9'(n_mc);
        n_rsp.now_empty  = (n_mc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            main_mem[r_mc[AW-1:0]] <= main_wd;
        end
        r_main_q <= main_mem[mc_dec[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (aux_we) begin
            aux_mem[r_ac[AW-1:0]] <= r_pivot;
        end
        r_aux_q <= aux_mem[ac_dec[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mc    <= '0;
            r_ac    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mc    <= n_mc;
            r_ac    <= n_ac;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop   <= n_pop;
        r_pivot <= n_pivot;
        r_rsp   <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mc <= FULL_CNT) && ((r_mc + r_ac) <= FULL_CNT))
        else $error("stack counts exceed depth");

    a_aux_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_ac == '0))
        else $error("aux stack not empty between requests");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mc == '0 && i_req.req_type != REQ_PUSH && i_req.req_type != REQ_SORT)
        |=> (o_done && o_rsp.empty_error && o_rsp.read_value == EMPTY_READ))
        else $error("empty pop or peek not reported");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.full_drop) |-> (r_mc == FULL_CNT))
        else $error("push dropped while stack not full");

    a_sort_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POUR && n_state == S_IDLE) |-> (r_ac == '0))
        else $error("sort finished with words left on aux stack");

endmodule

`default_nettype wire
